// ===== rtl/ipbl_pkg.sv =====
package ipbl_pkg;

  localparam int ADDR_W = 128;
  localparam int HALF_W = 64;
  localparam int V4_W   = 32;
  localparam int PFX_W  = 8;
  localparam int HELD_W = 6;
  // family bit, range start, range end
  localparam int RULE_W = 1 + 2 * ADDR_W;

  localparam logic [PFX_W-1:0] V4_PFX_MAX = PFX_W'(V4_W);
  localparam logic [PFX_W-1:0] V6_PFX_MAX = PFX_W'(ADDR_W);

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_EXACT  = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_SUBNET = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic check_start;
    logic add;
    logic scan_rd;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/ipbl_ram.sv =====
module ipbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ipbl_ctrl.sv =====
module ipbl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  ipbl_pkg::dp_status_t   status_i,
  output ipbl_pkg::ctrl_cmd_t    cmd_o
);
  import ipbl_pkg::*;

  state_e state_q, state_d;
  logic   is_check;

  assign is_check = (cmd_e'(cmd_i) == CMD_CHECK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_check && !status_i.cnt_zero) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.check_start = in_valid_i && is_check;
        cmd_o.add         = in_valid_i && !is_check;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RESULT: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/ipbl_dpath.sv =====
module ipbl_dpath #(
  parameter int MAX_RULES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ipbl_pkg::ctrl_cmd_t               cmd_i,
  output ipbl_pkg::dp_status_t              status_o,
  input  logic [1:0]                        cmd_op_i,
  input  logic                              is_ipv6_i,
  input  logic [ipbl_pkg::HALF_W-1:0]       addr_hi_i,
  input  logic [ipbl_pkg::HALF_W-1:0]       addr_lo_i,
  input  logic [ipbl_pkg::HALF_W-1:0]       end_hi_i,
  input  logic [ipbl_pkg::HALF_W-1:0]       end_lo_i,
  input  logic [ipbl_pkg::PFX_W-1:0]        prefix_len_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              blocked_o,
  output logic                              resp_status_o,
  output logic [ipbl_pkg::HELD_W-1:0]       rules_held_o
);
  import ipbl_pkg::*;

  localparam int CntW = $clog2(MAX_RULES + 1);
  localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [ADDR_W-1:0] Ones   = '1;
  localparam logic [ADDR_W-1:0] V4Mask = {{(ADDR_W - V4_W){1'b0}}, {V4_W{1'b1}}};
  localparam logic [V4_W-1:0]   Ones4  = '1;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              rd_vld_q;
  logic              hit_q, hit_d;
  logic              pend_status_q, pend_status_d;
  logic              q_fam_q;
  logic [ADDR_W-1:0] q_addr_q;
  logic              out_valid_q, out_valid_d;
  logic              out_blocked_q;
  logic              out_status_q;
  logic [HELD_W-1:0] out_held_q;

  logic              full;
  logic [CntW-1:0]   cnt_m1;
  logic [ADDR_W-1:0] in_addr, in_end, fam_mask, net_mask;
  logic [PFX_W-1:0]  pfx_sat;
  logic [V4_W-1:0]   mask4;
  logic [ADDR_W-1:0] wr_start, wr_end;
  logic [RULE_W-1:0] wr_data, rd_data;
  logic              we;
  logic              rd_fam;
  logic [ADDR_W-1:0] rd_start, rd_end;
  logic              rule_hit;
  logic [HELD_W+CntW-1:0] held_ext;

  assign full   = (cnt_q == CntW'(MAX_RULES));
  assign cnt_m1 = cnt_q - CntW'(1);

  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.scan_last = (idx_q == cnt_m1[AW-1:0]);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // rule encoding: every kind is stored as an inclusive range
  assign fam_mask = is_ipv6_i ? Ones : V4Mask;
  assign in_addr  = {addr_hi_i, addr_lo_i} & fam_mask;
  assign in_end   = {end_hi_i, end_lo_i} & fam_mask;

  always_comb begin
    if (is_ipv6_i) begin
      pfx_sat = (prefix_len_i > V6_PFX_MAX) ? V6_PFX_MAX : prefix_len_i;
    end else begin
      pfx_sat = (prefix_len_i > V4_PFX_MAX) ? V4_PFX_MAX : prefix_len_i;
    end
  end

  assign mask4    = ~(Ones4 >> pfx_sat);
  assign net_mask = is_ipv6_i ? ~(Ones >> pfx_sat)
                              : {{(ADDR_W - V4_W){1'b0}}, mask4};

  always_comb begin
    unique case (cmd_e'(cmd_op_i))
      CMD_RANGE: begin
        wr_start = in_addr;
        wr_end   = in_end;
      end
      CMD_SUBNET: begin
        wr_start = in_addr & net_mask;
        wr_end   = (in_addr | ~net_mask) & fam_mask;
      end
      default: begin
        wr_start = in_addr;
        wr_end   = in_addr;
      end
    endcase
  end

  assign wr_data = {is_ipv6_i, wr_start, wr_end};
  assign we      = cmd_i.add && !full;

  ipbl_ram #(
    .Width(RULE_W),
    .Depth(MAX_RULES)
  ) u_rules (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(wr_data),
    .re_i   (cmd_i.scan_rd),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  assign rd_fam   = rd_data[RULE_W-1];
  assign rd_start = rd_data[2*ADDR_W-1:ADDR_W];
  assign rd_end   = rd_data[ADDR_W-1:0];
  assign rule_hit = rd_vld_q && (rd_fam == q_fam_q) &&
                    (rd_start <= q_addr_q) && (q_addr_q <= rd_end);

  always_comb begin
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    hit_d         = hit_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;
    if (cmd_i.add) begin
      hit_d         = 1'b0;
      pend_status_d = full;
      if (!full) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
    if (cmd_i.check_start) begin
      idx_d         = '0;
      hit_d         = 1'b0;
      pend_status_d = 1'b0;
    end
    if (cmd_i.scan_rd) begin
      idx_d = idx_q + AW'(1);
    end
    if (rule_hit) begin
      hit_d = 1'b1;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      idx_q         <= '0;
      rd_vld_q      <= 1'b0;
      hit_q         <= 1'b0;
      pend_status_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cnt_q         <= cnt_d;
      idx_q         <= idx_d;
      rd_vld_q      <= cmd_i.scan_rd;
      hit_q         <= hit_d;
      pend_status_q <= pend_status_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign held_ext = {{HELD_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.check_start) begin
      q_fam_q  <= is_ipv6_i;
      q_addr_q <= in_addr;
    end
    if (cmd_i.load_out) begin
      out_blocked_q <= hit_q;
      out_status_q  <= pend_status_q;
      out_held_q    <= held_ext[HELD_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign blocked_o     = out_blocked_q;
  assign resp_status_o = out_status_q;
  assign rules_held_o  = out_held_q;

endmodule

// ===== rtl/ip_blocklist_match_top.sv =====
// Address blocklist table. An add request (exact address, inclusive range or
// subnet, IPv4 or IPv6) appends one rule and answers from the result state; when
// the table already holds MAX_RULES rules the rule is dropped and status is 1. A
// check request reads the stored rules from the rule memory one per cycle in the
// scan state, then passes the drain and result states (straight to result when
// the table is empty), and answers blocked = 1 if any rule of the same family covers the address.
// One request is worked on at a time; the result sits in an output register,
// so the next request is taken while an earlier result waits to be read.
module ip_blocklist_match_top #(
  parameter int MAX_RULES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic                          is_ipv6_i,
  input  logic [ipbl_pkg::HALF_W-1:0]   addr_hi_i,
  input  logic [ipbl_pkg::HALF_W-1:0]   addr_lo_i,
  input  logic [ipbl_pkg::HALF_W-1:0]   end_hi_i,
  input  logic [ipbl_pkg::HALF_W-1:0]   end_lo_i,
  input  logic [ipbl_pkg::PFX_W-1:0]    prefix_len_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          blocked_o,
  output logic                          status_o,
  output logic [ipbl_pkg::HELD_W-1:0]   rules_held_o
);
  import ipbl_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  ipbl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i     (cmd_i),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  ipbl_dpath #(
    .MAX_RULES(MAX_RULES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .cmd_op_i     (cmd_i),
    .is_ipv6_i    (is_ipv6_i),
    .addr_hi_i    (addr_hi_i),
    .addr_lo_i    (addr_lo_i),
    .end_hi_i     (end_hi_i),
    .end_lo_i     (end_lo_i),
    .prefix_len_i (prefix_len_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .blocked_o    (blocked_o),
    .resp_status_o(status_o),
    .rules_held_o (rules_held_o)
  );

endmodule

// ===== rtl/ipbl_checker.sv =====
module ipbl_checker #(
  parameter int MAX_RULES = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          blocked_o,
  input logic                          status_o,
  input logic [ipbl_pkg::HELD_W-1:0]   rules_held_o
);
  import ipbl_pkg::*;

  localparam logic [HELD_W-1:0] FullHeld = HELD_W'(MAX_RULES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rules_held_o))
    else $error("rules_held changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(blocked_o && status_o))
    else $error("blocked and table-full flagged together");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> rules_held_o == FullHeld)
    else $error("table-full status with table not full");

endmodule

bind ip_blocklist_match_top ipbl_checker #(.MAX_RULES(MAX_RULES)) u_checker (.*);

// ===== verif/tb.sv =====
module tb;
  import ipbl_pkg::*;

  localparam int TABLE_DEPTH = 32;
  // leave room for the catch-all rules added once the random traffic is done
  localparam int RANDOM_RULE_CAP = TABLE_DEPTH - 5;
  localparam int IDLE_PCT = 29;
  localparam int VERDICT_DEPTH = 16;

  typedef struct {
    cmd_e              cmd;
    logic              v6;
    logic [HALF_W-1:0] a_hi;
    logic [HALF_W-1:0] a_lo;
    logic [HALF_W-1:0] e_hi;
    logic [HALF_W-1:0] e_lo;
    logic [PFX_W-1:0]  pfx;
  } acl_req_t;

  typedef struct {
    logic              blocked;
    logic              full;
    logic [HELD_W-1:0] held;
  } acl_resp_t;

  typedef struct {
    cmd_e              kind;
    logic              v6;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [PFX_W-1:0]  pfx;
  } acl_rule_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        req_cmd = CMD_CHECK;
  logic              req_v6 = 1'b0;
  logic [HALF_W-1:0] req_addr_hi = '0;
  logic [HALF_W-1:0] req_addr_lo = '0;
  logic [HALF_W-1:0] req_end_hi = '0;
  logic [HALF_W-1:0] req_end_lo = '0;
  logic [PFX_W-1:0]  req_pfx = '0;
  logic              out_valid;
  logic              out_rdy = 1'b0;
  logic              blocked;
  logic              status;
  logic [HELD_W-1:0] rules_held;

  acl_rule_t   rule_tab[TABLE_DEPTH];
  int unsigned rules_stored = 0;
  // expected results in request order, written by the sender, read by the checker
  acl_resp_t   verdict_mem[VERDICT_DEPTH];
  int unsigned verdict_wr = 0;
  int unsigned verdict_rd = 0;
  int unsigned src_idle_pct = IDLE_PCT;
  int unsigned sink_idle_pct = IDLE_PCT;
  int unsigned errors = 0;

  ip_blocklist_match_top #(
    .MAX_RULES(TABLE_DEPTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (req_cmd),
    .is_ipv6_i   (req_v6),
    .addr_hi_i   (req_addr_hi),
    .addr_lo_i   (req_addr_lo),
    .end_hi_i    (req_end_hi),
    .end_lo_i    (req_end_lo),
    .prefix_len_i(req_pfx),
    .out_valid_o (out_valid),
    .out_ready_i (out_rdy),
    .blocked_o   (blocked),
    .status_o    (status),
    .rules_held_o(rules_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------- acl table predictor ----------------

  function automatic logic [ADDR_W-1:0] net_mask(logic v6, logic [PFX_W-1:0] pfx);
    logic [V4_W-1:0] m4;
    if (pfx == '0) return '0;
    if (v6) return {ADDR_W{1'b1}} << (ADDR_W - int'(pfx));
    m4 = {V4_W{1'b1}} << (V4_W - int'(pfx));
    return {{(ADDR_W-V4_W){1'b0}}, m4};
  endfunction

  function automatic logic [ADDR_W-1:0] full_addr(logic v6, logic [HALF_W-1:0] hi,
                                                  logic [HALF_W-1:0] lo);
    // ipv4 keeps only the low 32 bits
    return v6 ? {hi, lo} : {{(ADDR_W-V4_W){1'b0}}, lo[V4_W-1:0]};
  endfunction

  function automatic logic rule_hits(acl_rule_t r, logic [ADDR_W-1:0] a);
    case (r.kind)
      CMD_EXACT:  return a == r.first;
      CMD_RANGE:  return (r.first <= a) && (a <= r.last);
      CMD_SUBNET: return ((a ^ r.first) & net_mask(r.v6, r.pfx)) == '0;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic acl_resp_t acl_apply(acl_req_t q);
    acl_resp_t         rsp;
    acl_rule_t         r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] e;
    logic [PFX_W-1:0]  p;
    rsp.blocked = 1'b0;
    rsp.full = 1'b0;
    a = full_addr(q.v6, q.a_hi, q.a_lo);
    e = full_addr(q.v6, q.e_hi, q.e_lo);
    p = q.pfx;
    if (!q.v6 && p > V4_PFX_MAX) p = V4_PFX_MAX;
    if (q.v6 && p > V6_PFX_MAX) p = V6_PFX_MAX;
    if (q.cmd == CMD_CHECK) begin
      for (int i = 0; i < rules_stored; i++) begin
        if (rule_tab[i].v6 == q.v6 && rule_hits(rule_tab[i], a)) rsp.blocked = 1'b1;
      end
    end else if (rules_stored >= TABLE_DEPTH) begin
      rsp.full = 1'b1;
    end else begin
      r.kind = q.cmd;
      r.v6 = q.v6;
      r.first = a;
      r.last = (q.cmd == CMD_RANGE) ? e : a;
      r.pfx = (q.cmd == CMD_SUBNET) ? p : '0;
      rule_tab[rules_stored] = r;
      rules_stored++;
    end
    rsp.held = HELD_W'(rules_stored);
    return rsp;
  endfunction

  // ---------------- request generation ----------------

  function automatic logic [HALF_W-1:0] rand_half();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // every field starts as noise, the caller sets what the command uses
  function automatic acl_req_t garbage_req(cmd_e c, logic v6);
    acl_req_t q;
    q.cmd = c;
    q.v6 = v6;
    q.a_hi = rand_half();
    q.a_lo = rand_half();
    q.e_hi = rand_half();
    q.e_lo = rand_half();
    q.pfx = PFX_W'($urandom_range(255));
    return q;
  endfunction

  function automatic acl_req_t place(acl_req_t q, logic [ADDR_W-1:0] a,
                                     logic [ADDR_W-1:0] e);
    if (q.v6) begin
      {q.a_hi, q.a_lo} = a;
      {q.e_hi, q.e_lo} = e;
    end else begin
      q.a_lo[V4_W-1:0] = a[V4_W-1:0];
      q.e_lo[V4_W-1:0] = e[V4_W-1:0];
    end
    return q;
  endfunction

  function automatic acl_req_t random_rule_req();
    acl_req_t          q;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] e;
    int unsigned       pick;
    q = garbage_req(cmd_e'($urandom_range(1, 3)), 1'($urandom_range(1)));
    a = q.v6 ? {rand_half(), rand_half()} : {{(ADDR_W-V4_W){1'b0}}, $urandom};
    pick = $urandom_range(99);
    if (pick < 75) e = a + $urandom_range(4096);
    else if (pick < 90) e = a - $urandom_range(4096, 1);
    else e = {rand_half(), rand_half()};
    q = place(q, a, e);
    if (q.cmd == CMD_SUBNET) begin
      if ($urandom_range(99) < 70)
        q.pfx = q.v6 ? PFX_W'($urandom_range(128, 32)) : PFX_W'($urandom_range(32, 16));
      else
        q.pfx = q.v6 ? PFX_W'($urandom_range(255, 129)) : PFX_W'($urandom_range(255, 33));
    end
    return q;
  endfunction

  // check request aimed at or just beside a stored rule, or plain noise
  function automatic acl_req_t probe_req();
    acl_req_t          q;
    acl_rule_t         r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] m;
    int unsigned       bitpos;
    if (rules_stored == 0 || $urandom_range(99) < 30) begin
      q = garbage_req(CMD_CHECK, 1'($urandom_range(1)));
      return q;
    end
    r = rule_tab[$urandom_range(rules_stored - 1)];
    q = garbage_req(CMD_CHECK, ($urandom_range(9) == 0) ? ~r.v6 : r.v6);
    case (r.kind)
      CMD_EXACT: begin
        case ($urandom_range(3))
          0:       a = r.first - 1;
          1:       a = r.first + 1;
          default: a = r.first;
        endcase
      end
      CMD_RANGE: begin
        case ($urandom_range(4))
          0:       a = r.first;
          1:       a = r.last;
          2:       a = r.first - 1;
          3:       a = r.last + 1;
          default: a = r.first + $urandom_range(4096);
        endcase
      end
      default: begin
        m = net_mask(r.v6, r.pfx);
        a = (r.first & m) | ({rand_half(), rand_half()} & ~m);
        if (r.pfx != '0 && $urandom_range(3) == 0) begin
          bitpos = (r.v6 ? ADDR_W : V4_W) - 1 - $urandom_range(int'(r.pfx) - 1);
          a[bitpos] = ~a[bitpos];
        end
      end
    endcase
    return place(q, a, a);
  endfunction

  // ---------------- request driver and result checker ----------------

  task automatic send_request(acl_req_t q);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_cmd <= q.cmd;
    req_v6 <= q.v6;
    req_addr_hi <= q.a_hi;
    req_addr_lo <= q.a_lo;
    req_end_hi <= q.e_hi;
    req_end_lo <= q.e_lo;
    req_pfx <= q.pfx;
    do @(posedge clk); while (!in_ready);
    verdict_mem[verdict_wr % VERDICT_DEPTH] = acl_apply(q);
    verdict_wr++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_wr != verdict_rd) @(posedge clk);
  endtask

  always @(negedge clk) out_rdy <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    acl_resp_t want;
    if (rst_n && out_valid && out_rdy) begin
      if (verdict_wr == verdict_rd) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: blocked %0b status %0b held %0d",
                   blocked, status, rules_held);
      end else begin
        want = verdict_mem[verdict_rd % VERDICT_DEPTH];
        verdict_rd++;
        if (blocked !== want.blocked || status !== want.full || rules_held !== want.held) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: blocked exp %0b got %0b, status exp %0b got %0b, held exp %0d got %0d",
                     want.blocked, blocked, want.full, status, want.held, rules_held);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic send_fields(cmd_e c, logic v6, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] e,
                             logic [PFX_W-1:0] p);
    acl_req_t q;
    q = place(garbage_req(c, v6), a, e);
    if (c == CMD_SUBNET) q.pfx = p;
    send_request(q);
  endtask

  task automatic test_directed_cases();
    logic [ADDR_W-1:0] r6_lo;
    logic [ADDR_W-1:0] r6_hi;
    r6_lo = 128'h2001_0db8_0000_0000_ffff_ffff_ffff_fff0;
    r6_hi = 128'h2001_0db8_0000_0001_0000_0000_0000_000f;
    // lookups on an empty table
    send_fields(CMD_CHECK, 1'b0, '0, '0, '0);
    send_fields(CMD_CHECK, 1'b1, '1, '1, '0);
    // ipv4 upper bits are noise on both the add and the check
    send_fields(CMD_EXACT, 1'b0, 128'hc0a8_0101, '1, 8'hff);
    send_fields(CMD_CHECK, 1'b0, 128'hc0a8_0101, '0, '0);
    send_fields(CMD_CHECK, 1'b1, 128'hc0a8_0101, '0, '0);
    send_fields(CMD_CHECK, 1'b0, 128'hc0a8_0102, '0, '0);
    // inverted range covers nothing
    send_fields(CMD_RANGE, 1'b0, 128'h0a00_0010, 128'h0a00_0000, '0);
    send_fields(CMD_CHECK, 1'b0, 128'h0a00_0008, '0, '0);
    // ipv6 range crossing the half boundary, probed at and beside its ends
    send_fields(CMD_RANGE, 1'b1, r6_lo, r6_hi, '0);
    send_fields(CMD_CHECK, 1'b1, r6_lo, '0, '0);
    send_fields(CMD_CHECK, 1'b1, r6_hi, '0, '0);
    send_fields(CMD_CHECK, 1'b1, r6_hi + 1, '0, '0);
    send_fields(CMD_CHECK, 1'b1, r6_lo - 1, '0, '0);
    send_fields(CMD_CHECK, 1'b1, 128'h2001_0db8_0000_0001_0000_0000_0000_0000, '0, '0);
    send_fields(CMD_SUBNET, 1'b0, 128'hac10_0000, '0, 8'd12);
    send_fields(CMD_CHECK, 1'b0, 128'hac1f_ffff, '0, '0);
    send_fields(CMD_CHECK, 1'b0, 128'hac20_0000, '0, '0);
    // prefix longer than the family collapses to an exact match
    send_fields(CMD_SUBNET, 1'b0, 128'h0808_0808, '0, 8'hff);
    send_fields(CMD_CHECK, 1'b0, 128'h0808_0809, '0, '0);
    send_fields(CMD_CHECK, 1'b0, 128'h0808_0808, '0, '0);
    send_fields(CMD_SUBNET, 1'b1, '1, '0, 8'd129);
    send_fields(CMD_CHECK, 1'b1, '1, '0, '0);
    send_fields(CMD_EXACT, 1'b1, '0, '1, 8'd128);
    send_fields(CMD_CHECK, 1'b1, '0, '0, '0);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    repeat (n_items) begin
      if (rules_stored < RANDOM_RULE_CAP && $urandom_range(99) < 2)
        send_request(random_rule_req());
      else
        send_request(probe_req());
      if ($urandom_range(249) == 0) wait_all_results();
    end
  endtask

  task automatic test_back_to_back(int unsigned n_items);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(n_items);
    src_idle_pct = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  task automatic test_table_full();
    // zero prefix catches every address of its family
    send_fields(CMD_SUBNET, 1'b1, {rand_half(), rand_half()}, '0, 8'd0);
    send_fields(CMD_SUBNET, 1'b0, {rand_half(), rand_half()}, '0, 8'd0);
    while (rules_stored < TABLE_DEPTH) send_request(random_rule_req());
    // adds beyond capacity are dropped
    for (int c = CMD_EXACT; c <= CMD_SUBNET; c++) begin
      send_request(garbage_req(cmd_e'(c), 1'b0));
      send_request(garbage_req(cmd_e'(c), 1'b1));
    end
    repeat (40) send_request(probe_req());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_random_traffic(720);
    wait_all_results();
    test_back_to_back(300);
    test_random_traffic(820);
    test_table_full();
    wait_all_results();
    repeat (60) @(posedge clk);
    if (errors == 0 && verdict_wr == verdict_rd) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
